### hdl/btsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsd_pkg
// Types and constants shared by the binary token stream decoder.
// ----------------------------------------------------------------------------
package btsd_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int MAX_TOKENS  = 1024;

  localparam int SpW     = $clog2(STACK_DEPTH + 1);
  localparam int StkIdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int TokIdxW = $clog2(MAX_TOKENS);
  localparam int CountW  = TokIdxW + 1;

  localparam logic [4:0] LenCodeMask = 5'h1F;
  localparam logic [4:0] LenCodeMax  = 5'd27;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_REPORT  = 2'd2;

  localparam logic [2:0] TY_BYTES  = 3'd0;
  localparam logic [2:0] TY_STRING = 3'd1;
  localparam logic [2:0] TY_ARRAY  = 3'd2;
  localparam logic [2:0] TY_OBJECT = 3'd3;
  localparam logic [2:0] TY_BOOL   = 3'd4;
  localparam logic [2:0] TY_NULL   = 3'd6;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_UNTERMINATED = 3'd1;
  localparam logic [2:0] ST_BAD_REF      = 3'd2;
  localparam logic [2:0] ST_TRUNCATED    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW     = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd5;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_LEN  = 3'd1,
    PH_KEY  = 3'd2,
    PH_KEY2 = 3'd3,
    PH_PAY  = 3'd4,
    PH_TERM = 3'd5,
    PH_ERR  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_REF  = 2'd1,
    CTL_POP  = 2'd2
  } ctl_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  token_type;
    logic [31:0] token_length;
    logic [15:0] token_key;
    logic [9:0]  token_index;
    logic [4:0]  nest_depth;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        end_flag;
  } res_t;

endpackage

### hdl/binary_token_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_token_stream_decoder_unit
// Decodes a serialized token stream one byte per request into header,
// payload and end-of-message records.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry data_byte_i and last_i.
// Output channel: out_valid_o / out_stall_i carry one record per request.
// Each byte is decoded in the cycle it is taken; a record it gives at once
// appears in the output register on the next cycle.
// Throughput is one byte per cycle while the output is free and no lookup or
// pop is pending. A byte that gives two records (a record plus the end report)
// holds the input while the second record drains from a one-entry skid register.
// A reference token reads the token table, which has a registered read port;
// the input stalls until the lookup is done. Closing nested containers pops the
// stack one level per cycle while the output is free, and the input stalls
// until the last pop is done.
// Reset clears all control state; the stack and the token table are not
// cleared and are only read where written. The byte marked last restores
// the reset state after its report.
// While the receiver stalls, the output register holds; the input stalls
// as soon as no space remains for the results of one more byte.
// ----------------------------------------------------------------------------
module binary_token_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  token_type_o,
  output logic [31:0] token_length_o,
  output logic [15:0] token_key_o,
  output logic [9:0]  token_index_o,
  output logic [4:0]  nest_depth_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic        end_flag_o
);

  localparam int SD = btsd_pkg::STACK_DEPTH;
  localparam int MT = btsd_pkg::MAX_TOKENS;

  btsd_pkg::phase_e phase_q, phase_d;
  btsd_pkg::ctl_e   ctl_q, ctl_d;
  logic [2:0]  htype_q, htype_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  lbl_q, lbl_d;
  logic [15:0] key_q, key_d;
  logic [31:0] pay_q, pay_d;
  logic [btsd_pkg::SpW-1:0]    sp_q, sp_d;
  logic [btsd_pkg::CountW-1:0] count_q, count_d;
  logic [2:0]  err_q, err_d;
  logic        last_q, last_d;

  logic [31:0] stk_rem_q  [SD];
  logic        stk_obj_q  [SD];
  logic [15:0] stk_nidx_q [SD];

  logic [34:0] tab_mem [MT];
  logic [34:0] tab_rd_q;

  btsd_pkg::res_t out_q, pend_q, rec, rep;
  logic out_valid_q, pend_valid_q;
  logic rec_v, rep_v;

  logic out_free, go, accept;
  logic [btsd_pkg::SpW-1:0]     sp_m1;
  logic [btsd_pkg::StkIdxW-1:0] top;
  logic [15:0] cur_key;
  logic [31:0] acc_n, ref_idx, top_rem_n;
  logic [4:0]  code;
  logic        hdr_go, cd_go, fin, lastflag;
  logic [2:0]  h_type;
  logic [31:0] h_len;
  logic        stk_we;
  logic [btsd_pkg::StkIdxW-1:0] stk_widx;
  logic [31:0] stk_wrem;
  logic        stk_wobj;
  logic [15:0] stk_wnidx;
  logic        tab_we, tab_re;
  logic [2:0]  tab_wtype;
  logic [31:0] tab_wlen;
  logic [btsd_pkg::TokIdxW-1:0] tab_raddr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = out_free && !pend_valid_q;

  always_comb begin
    in_stall_o = !(go && ctl_q == btsd_pkg::CTL_IDLE);
  end

  assign accept = in_valid_i && !in_stall_o;
  assign sp_m1  = sp_q - 1'b1;
  assign top    = sp_m1[btsd_pkg::StkIdxW-1:0];
  assign cur_key = (sp_q == '0) ? 16'd0 : (stk_obj_q[top] ? key_q : stk_nidx_q[top]);
  assign code   = data_byte_i[4:0] & btsd_pkg::LenCodeMask;
  assign acc_n  = {acc_q[23:0], data_byte_i};
  assign top_rem_n = stk_rem_q[top] - 32'd1;

  always_comb begin
    phase_d = phase_q;
    ctl_d   = ctl_q;
    htype_d = htype_q;
    acc_d   = acc_q;
    lbl_d   = lbl_q;
    key_d   = key_q;
    pay_d   = pay_q;
    sp_d    = sp_q;
    count_d = count_q;
    err_d   = err_q;
    last_d  = last_q;
    rec     = '0;
    rec_v   = 1'b0;
    rep     = '0;
    rep_v   = 1'b0;
    hdr_go  = 1'b0;
    cd_go   = 1'b0;
    fin     = 1'b0;
    h_type  = htype_q;
    h_len   = acc_q;
    ref_idx = h_len - 32'd2;
    stk_we    = 1'b0;
    stk_widx  = top;
    stk_wrem  = top_rem_n;
    stk_wobj  = stk_obj_q[top];
    stk_wnidx = stk_nidx_q[top] + 16'd1;
    tab_we    = 1'b0;
    tab_re    = 1'b0;
    tab_wtype = h_type;
    tab_wlen  = h_len;
    tab_raddr = ref_idx[btsd_pkg::TokIdxW-1:0];
    lastflag  = accept ? last_i : last_q;

    if (accept) begin
      last_d = last_i;
      case (phase_q)
        btsd_pkg::PH_HEAD: begin
          htype_d = data_byte_i[7:5];
          if (code > btsd_pkg::LenCodeMax) begin
            lbl_d   = 3'(code - btsd_pkg::LenCodeMax);
            acc_d   = '0;
            phase_d = btsd_pkg::PH_LEN;
            fin     = 1'b1;
          end else begin
            hdr_go = 1'b1;
            h_type = data_byte_i[7:5];
            h_len  = {27'd0, code};
          end
        end
        btsd_pkg::PH_LEN: begin
          acc_d = acc_n;
          lbl_d = lbl_q - 3'd1;
          if (lbl_q == 3'd1) begin
            hdr_go = 1'b1;
            h_len  = acc_n;
          end else begin
            fin = 1'b1;
          end
        end
        btsd_pkg::PH_KEY: begin
          key_d   = {data_byte_i, 8'd0};
          phase_d = btsd_pkg::PH_KEY2;
          fin     = 1'b1;
        end
        btsd_pkg::PH_KEY2: begin
          key_d   = {key_q[15:8], data_byte_i};
          phase_d = btsd_pkg::PH_HEAD;
          fin     = 1'b1;
        end
        btsd_pkg::PH_PAY: begin
          rec_v = 1'b1;
          rec.kind = btsd_pkg::KIND_PAYLOAD;
          rec.payload_byte = data_byte_i;
          pay_d = pay_q - 32'd1;
          if (pay_q == 32'd1) begin
            if (htype_q == btsd_pkg::TY_STRING) begin
              phase_d = btsd_pkg::PH_TERM;
              fin = 1'b1;
            end else begin
              cd_go = 1'b1;
            end
          end else begin
            fin = 1'b1;
          end
        end
        btsd_pkg::PH_TERM: begin
          if (data_byte_i != 8'd0) begin
            err_d   = (err_q == btsd_pkg::ST_OK) ? btsd_pkg::ST_UNTERMINATED : err_q;
            phase_d = btsd_pkg::PH_ERR;
            fin     = 1'b1;
          end else begin
            cd_go = 1'b1;
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
    end

    ref_idx   = h_len - 32'd2;
    tab_raddr = ref_idx[btsd_pkg::TokIdxW-1:0];
    tab_wtype = h_type;
    tab_wlen  = h_len;

    if (hdr_go) begin
      if (h_type == btsd_pkg::TY_NULL && h_len != 32'd0) begin
        cd_go = 1'b1;
      end else if (count_q >= btsd_pkg::CountW'(MT)) begin
        err_d   = (err_q == btsd_pkg::ST_OK) ? btsd_pkg::ST_TABLE_FULL : err_q;
        phase_d = btsd_pkg::PH_ERR;
        fin     = 1'b1;
      end else if (h_type == btsd_pkg::TY_BOOL && h_len > 32'd1) begin
        if (ref_idx >= 32'(count_q)) begin
          err_d   = (err_q == btsd_pkg::ST_OK) ? btsd_pkg::ST_BAD_REF : err_q;
          phase_d = btsd_pkg::PH_ERR;
          fin     = 1'b1;
        end else begin
          tab_re = 1'b1;
          ctl_d  = btsd_pkg::CTL_REF;
        end
      end else if ((h_type == btsd_pkg::TY_ARRAY || h_type == btsd_pkg::TY_OBJECT)
                   && h_len != 32'd0 && sp_q >= btsd_pkg::SpW'(SD)) begin
        err_d   = (err_q == btsd_pkg::ST_OK) ? btsd_pkg::ST_OVERFLOW : err_q;
        phase_d = btsd_pkg::PH_ERR;
        fin     = 1'b1;
      end else begin
        tab_we  = 1'b1;
        count_d = count_q + 1'b1;
        htype_d = h_type;
        rec_v   = 1'b1;
        rec.kind         = btsd_pkg::KIND_HEADER;
        rec.token_type   = h_type;
        rec.token_length = h_len;
        rec.token_key    = cur_key;
        rec.token_index  = 10'(count_q);
        rec.nest_depth   = 5'(sp_q);
        if (h_type == btsd_pkg::TY_ARRAY || h_type == btsd_pkg::TY_OBJECT) begin
          if (h_len == 32'd0) begin
            cd_go = 1'b1;
          end else begin
            stk_we    = 1'b1;
            stk_widx  = sp_q[btsd_pkg::StkIdxW-1:0];
            stk_wrem  = h_len;
            stk_wobj  = (h_type == btsd_pkg::TY_OBJECT);
            stk_wnidx = 16'd0;
            sp_d      = sp_q + 1'b1;
            phase_d   = (h_type == btsd_pkg::TY_OBJECT) ? btsd_pkg::PH_KEY : btsd_pkg::PH_HEAD;
            fin       = 1'b1;
          end
        end else if (h_type == btsd_pkg::TY_STRING || h_type == btsd_pkg::TY_BYTES) begin
          pay_d = h_len;
          if (h_len != 32'd0) begin
            phase_d = btsd_pkg::PH_PAY;
            fin = 1'b1;
          end else if (h_type == btsd_pkg::TY_STRING) begin
            phase_d = btsd_pkg::PH_TERM;
            fin = 1'b1;
          end else begin
            cd_go = 1'b1;
          end
        end else begin
          cd_go = 1'b1;
        end
      end
    end

    if (go && ctl_q == btsd_pkg::CTL_REF) begin
      if (tab_rd_q[34:32] >= btsd_pkg::TY_ARRAY) begin
        err_d   = (err_q == btsd_pkg::ST_OK) ? btsd_pkg::ST_BAD_REF : err_q;
        phase_d = btsd_pkg::PH_ERR;
        fin     = 1'b1;
      end else begin
        tab_we    = 1'b1;
        tab_wtype = tab_rd_q[34:32];
        tab_wlen  = tab_rd_q[31:0];
        count_d   = count_q + 1'b1;
        rec_v     = 1'b1;
        rec.kind         = btsd_pkg::KIND_HEADER;
        rec.token_type   = tab_rd_q[34:32];
        rec.token_length = tab_rd_q[31:0];
        rec.token_key    = cur_key;
        rec.token_index  = 10'(count_q);
        rec.nest_depth   = 5'(sp_q);
        cd_go = 1'b1;
      end
    end

    if (go && ctl_q == btsd_pkg::CTL_POP) begin
      cd_go = 1'b1;
    end

    // one stack level of child completion per cycle, while the output is free
    if (cd_go) begin
      if (sp_q == '0) begin
        phase_d = btsd_pkg::PH_HEAD;
        fin = 1'b1;
      end else begin
        stk_we = 1'b1;
        if (top_rem_n != 32'd0) begin
          phase_d = stk_obj_q[top] ? btsd_pkg::PH_KEY : btsd_pkg::PH_HEAD;
          fin = 1'b1;
        end else begin
          sp_d = sp_m1;
          if (sp_m1 == '0) begin
            phase_d = btsd_pkg::PH_HEAD;
            fin = 1'b1;
          end else begin
            ctl_d = btsd_pkg::CTL_POP;
          end
        end
      end
    end

    rec.end_flag = !lastflag;

    if (fin) begin
      ctl_d = btsd_pkg::CTL_IDLE;
      if (lastflag) begin
        rep_v = 1'b1;
        rep.kind = btsd_pkg::KIND_REPORT;
        rep.end_flag = 1'b1;
        if (err_d != btsd_pkg::ST_OK) begin
          rep.status = err_d;
        end else if (phase_d != btsd_pkg::PH_HEAD || sp_d != '0) begin
          rep.status = btsd_pkg::ST_TRUNCATED;
        end else begin
          rep.status = btsd_pkg::ST_OK;
        end
        phase_d = btsd_pkg::PH_HEAD;
        htype_d = '0;
        acc_d   = '0;
        lbl_d   = '0;
        key_d   = '0;
        pay_d   = '0;
        sp_d    = '0;
        count_d = '0;
        err_d   = '0;
        last_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= btsd_pkg::PH_HEAD;
      ctl_q        <= btsd_pkg::CTL_IDLE;
      htype_q      <= '0;
      acc_q        <= '0;
      lbl_q        <= '0;
      key_q        <= '0;
      pay_q        <= '0;
      sp_q         <= '0;
      count_q      <= '0;
      err_q        <= '0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ctl_q   <= ctl_d;
      htype_q <= htype_d;
      acc_q   <= acc_d;
      lbl_q   <= lbl_d;
      key_q   <= key_d;
      pay_q   <= pay_d;
      sp_q    <= sp_d;
      count_q <= count_d;
      err_q   <= err_d;
      last_q  <= last_d;
      if (out_free) begin
        if (pend_valid_q) begin
          out_valid_q  <= 1'b1;
          pend_valid_q <= 1'b0;
        end else begin
          out_valid_q  <= rec_v || rep_v;
          pend_valid_q <= rec_v && rep_v;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else begin
        out_q  <= rec_v ? rec : rep;
        pend_q <= rep;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_rem_q[stk_widx]  <= stk_wrem;
      stk_obj_q[stk_widx]  <= stk_wobj;
      stk_nidx_q[stk_widx] <= stk_wnidx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[count_q[btsd_pkg::TokIdxW-1:0]] <= {tab_wtype, tab_wlen};
    end
    if (tab_re) begin
      tab_rd_q <= tab_mem[tab_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign token_type_o   = out_q.token_type;
  assign token_length_o = out_q.token_length;
  assign token_key_o    = out_q.token_key;
  assign token_index_o  = out_q.token_index;
  assign nest_depth_o   = out_q.nest_depth;
  assign payload_byte_o = out_q.payload_byte;
  assign status_o       = out_q.status;
  assign end_flag_o     = out_q.end_flag;

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q != btsd_pkg::CTL_IDLE) |-> in_stall_o)
    else $error("input taken during lookup or pop");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= btsd_pkg::SpW'(SD))
    else $error("stack pointer out of range");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= btsd_pkg::CountW'(MT))
    else $error("token count out of range");
  a_ref_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q == btsd_pkg::CTL_REF && !$past(ctl_q == btsd_pkg::CTL_REF)) |-> $past(tab_re))
    else $error("reference wait without table read");
`endif

endmodule

### test/binary_token_stream_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_token_stream_decoder_unit_test
// Drives token stream messages byte by byte into the decoder: a few directed
// messages, then random well-formed, cut-off and noisy messages under varying
// idle patterns on both sides. A scoreboard predicts every record and checks
// each one as it leaves the block.
// ----------------------------------------------------------------------------
module binary_token_stream_decoder_unit_test;

  localparam int LIMIT = 400000;

  class decode_scoreboard;
    btsd_pkg::phase_e ph;
    logic [2:0]  htype;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    logic [15:0] key_acc;
    logic [31:0] pay_left;
    logic [31:0] stk_rem[btsd_pkg::STACK_DEPTH];
    logic        stk_obj[btsd_pkg::STACK_DEPTH];
    logic [15:0] stk_idx[btsd_pkg::STACK_DEPTH];
    int          sp;
    logic [2:0]  tok_type[btsd_pkg::MAX_TOKENS];
    logic [31:0] tok_len[btsd_pkg::MAX_TOKENS];
    int          tok_count;
    logic [2:0]  err;
    btsd_pkg::res_t pending[$];
    btsd_pkg::res_t step_recs[$];
    int          mismatches;

    function void clear_state();
      ph = btsd_pkg::PH_HEAD;
      htype = 0;
      len_acc = 0;
      len_left = 0;
      key_acc = 0;
      pay_left = 0;
      sp = 0;
      tok_count = 0;
      err = btsd_pkg::ST_OK;
    endfunction

    function void add_rec(logic [1:0] kind, logic [2:0] ty, logic [31:0] len,
                          logic [15:0] key, logic [9:0] idx, logic [4:0] depth,
                          logic [7:0] pb, logic [2:0] st);
      btsd_pkg::res_t r;
      r.kind = kind;
      r.token_type = ty;
      r.token_length = len;
      r.token_key = key;
      r.token_index = idx;
      r.nest_depth = depth;
      r.payload_byte = pb;
      r.status = st;
      r.end_flag = 1'b0;
      step_recs.push_back(r);
    endfunction

    function void fail_with(logic [2:0] code);
      if (err == btsd_pkg::ST_OK) err = code;
      ph = btsd_pkg::PH_ERR;
    endfunction

    function void close_child();
      int t;
      while (sp > 0) begin
        t = sp - 1;
        stk_rem[t] = stk_rem[t] - 1;
        stk_idx[t] = stk_idx[t] + 1;
        if (stk_rem[t] != 0) break;
        sp--;
      end
      ph = (sp > 0 && stk_obj[sp-1]) ? btsd_pkg::PH_KEY : btsd_pkg::PH_HEAD;
    endfunction

    function void open_token(logic [2:0] ty_in, logic [31:0] len_in);
      logic [15:0] key;
      logic [2:0]  ty;
      logic [31:0] len;
      int          idx;
      int          rf;
      ty = ty_in;
      len = len_in;
      idx = tok_count;
      key = (sp == 0) ? 16'd0 : (stk_obj[sp-1] ? key_acc : stk_idx[sp-1]);
      if (ty == btsd_pkg::TY_NULL && len > 0) begin
        close_child();
        return;
      end
      if (tok_count >= btsd_pkg::MAX_TOKENS) begin
        fail_with(btsd_pkg::ST_TABLE_FULL);
        return;
      end
      if (ty == btsd_pkg::TY_BOOL && len > 1) begin
        if (len - 2 >= tok_count) begin
          fail_with(btsd_pkg::ST_BAD_REF);
          return;
        end
        rf = len - 2;
        if (tok_type[rf] >= btsd_pkg::TY_ARRAY) begin
          fail_with(btsd_pkg::ST_BAD_REF);
          return;
        end
        ty = tok_type[rf];
        len = tok_len[rf];
        tok_type[idx] = ty;
        tok_len[idx] = len;
        tok_count++;
        add_rec(btsd_pkg::KIND_HEADER, ty, len, key, 10'(idx), 5'(sp), 8'd0,
                btsd_pkg::ST_OK);
        close_child();
        return;
      end
      if ((ty == btsd_pkg::TY_ARRAY || ty == btsd_pkg::TY_OBJECT) && len > 0
          && sp >= btsd_pkg::STACK_DEPTH) begin
        fail_with(btsd_pkg::ST_OVERFLOW);
        return;
      end
      tok_type[idx] = ty;
      tok_len[idx] = len;
      tok_count++;
      add_rec(btsd_pkg::KIND_HEADER, ty, len, key, 10'(idx), 5'(sp), 8'd0,
              btsd_pkg::ST_OK);
      htype = ty;
      if (ty == btsd_pkg::TY_ARRAY || ty == btsd_pkg::TY_OBJECT) begin
        if (len == 0) close_child();
        else begin
          stk_rem[sp] = len;
          stk_obj[sp] = (ty == btsd_pkg::TY_OBJECT);
          stk_idx[sp] = 0;
          sp++;
          ph = (ty == btsd_pkg::TY_OBJECT) ? btsd_pkg::PH_KEY : btsd_pkg::PH_HEAD;
        end
      end else if (ty == btsd_pkg::TY_STRING || ty == btsd_pkg::TY_BYTES) begin
        pay_left = len;
        if (len > 0) ph = btsd_pkg::PH_PAY;
        else if (ty == btsd_pkg::TY_STRING) ph = btsd_pkg::PH_TERM;
        else close_child();
      end else begin
        close_child();
      end
    endfunction

    function void note_request(logic [7:0] b, logic last);
      logic [2:0] st;
      step_recs.delete();
      case (ph)
        btsd_pkg::PH_HEAD: begin
          htype = b[7:5];
          if (b[4:0] > btsd_pkg::LenCodeMax) begin
            len_left = 3'(b[4:0] - btsd_pkg::LenCodeMax);
            len_acc = 0;
            ph = btsd_pkg::PH_LEN;
          end else open_token(htype, {27'd0, b[4:0]});
        end
        btsd_pkg::PH_LEN: begin
          len_acc = {len_acc[23:0], b};
          len_left = len_left - 3'd1;
          if (len_left == 0) open_token(htype, len_acc);
        end
        btsd_pkg::PH_KEY: begin
          key_acc = {b, 8'd0};
          ph = btsd_pkg::PH_KEY2;
        end
        btsd_pkg::PH_KEY2: begin
          key_acc = {key_acc[15:8], b};
          ph = btsd_pkg::PH_HEAD;
        end
        btsd_pkg::PH_PAY: begin
          add_rec(btsd_pkg::KIND_PAYLOAD, 3'd0, 32'd0, 16'd0, 10'd0, 5'd0, b,
                  btsd_pkg::ST_OK);
          pay_left--;
          if (pay_left == 0) begin
            if (htype == btsd_pkg::TY_STRING) ph = btsd_pkg::PH_TERM;
            else close_child();
          end
        end
        btsd_pkg::PH_TERM: begin
          if (b != 0) fail_with(btsd_pkg::ST_UNTERMINATED);
          else close_child();
        end
        default: ;
      endcase
      if (last) begin
        st = err;
        if (st == btsd_pkg::ST_OK && (ph != btsd_pkg::PH_HEAD || sp != 0))
          st = btsd_pkg::ST_TRUNCATED;
        add_rec(btsd_pkg::KIND_REPORT, 3'd0, 32'd0, 16'd0, 10'd0, 5'd0, 8'd0, st);
        clear_state();
      end
      if (step_recs.size() > 0) step_recs[step_recs.size()-1].end_flag = 1'b1;
      foreach (step_recs[i]) pending.push_back(step_recs[i]);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task compare_field(string what, longint got, longint want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    task check_result(btsd_pkg::res_t got);
      btsd_pkg::res_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected record kind", got.kind, -1);
        return;
      end
      want = pending.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("token_type", got.token_type, want.token_type);
      compare_field("token_length", got.token_length, want.token_length);
      compare_field("token_key", got.token_key, want.token_key);
      compare_field("token_index", got.token_index, want.token_index);
      compare_field("nest_depth", got.nest_depth, want.nest_depth);
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("status", got.status, want.status);
      compare_field("end_flag", got.end_flag, want.end_flag);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  btsd_pkg::res_t got;

  decode_scoreboard sb;
  int          cycles;
  int          send_idle;
  int          recv_idle;
  int          hold_left;
  int          items_sent;
  int          tok_guess;
  logic [7:0]  msg[$];

  binary_token_stream_decoder_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .last_i         (last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (got.kind),
    .token_type_o   (got.token_type),
    .token_length_o (got.token_length),
    .token_key_o    (got.token_key),
    .token_index_o  (got.token_index),
    .nest_depth_o   (got.nest_depth),
    .payload_byte_o (got.payload_byte),
    .status_o       (got.status),
    .end_flag_o     (got.end_flag)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[binary_token_stream_decoder_unit] ERROR");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(got);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task send_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b, l);
    items_sent++;
  endtask

  // whole message, last marked on its final byte
  task send_msg();
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  function automatic void put_header(logic [2:0] ty, logic [31:0] len, bit ext);
    int nb;
    if (len <= 27 && !ext) begin
      msg.push_back({ty, len[4:0]});
      return;
    end
    nb = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
    if (nb < 4 && $urandom_range(3) == 0) nb++;
    msg.push_back({ty, 5'(27 + nb)});
    for (int i = nb - 1; i >= 0; i--) msg.push_back(8'(len >> (8 * i)));
  endfunction

  function automatic void gen_value(int depth);
    int n;
    bit ext;
    logic [2:0] ty;
    ext = ($urandom_range(4) == 0);
    ty = 3'($urandom_range(7));
    case (ty)
      btsd_pkg::TY_BYTES, btsd_pkg::TY_STRING: begin
        n = $urandom_range(5);
        put_header(ty, n, ext);
        repeat (n) msg.push_back(8'($urandom));
        if (ty == btsd_pkg::TY_STRING)
          msg.push_back(($urandom_range(29) == 0) ? 8'($urandom_range(255, 1)) : 8'd0);
        tok_guess++;
      end
      btsd_pkg::TY_ARRAY, btsd_pkg::TY_OBJECT: begin
        n = (depth < 4) ? $urandom_range(3) : 0;
        put_header(ty, n, ext);
        tok_guess++;
        repeat (n) begin
          if (ty == btsd_pkg::TY_OBJECT) begin
            msg.push_back(8'($urandom));
            msg.push_back(8'($urandom));
          end
          gen_value(depth + 1);
        end
      end
      btsd_pkg::TY_BOOL: begin
        if ($urandom_range(1)) put_header(ty, $urandom_range(1), ext);
        else put_header(ty, 2 + $urandom_range(tok_guess + 1), ext);
        tok_guess++;
      end
      btsd_pkg::TY_NULL: begin
        if ($urandom_range(2) == 0) put_header(ty, $urandom_range(200, 1), ext);
        else begin
          put_header(ty, 0, ext);
          tok_guess++;
        end
      end
      default: begin
        put_header(ty, $urandom, $urandom_range(1));
        tok_guess++;
      end
    endcase
  endfunction

  task random_msg();
    int kind_sel;
    int cut;
    kind_sel = $urandom_range(99);
    tok_guess = 0;
    if (kind_sel < 6) begin
      repeat ($urandom_range(10, 1)) msg.push_back(8'($urandom));
    end else if (kind_sel < 10) begin
      // deep chain of single-child containers, around the stack limit
      repeat ($urandom_range(18, 14)) msg.push_back({btsd_pkg::TY_ARRAY, 5'd1});
      msg.push_back({btsd_pkg::TY_BOOL, 5'd1});
    end else begin
      repeat ($urandom_range(4, 1)) gen_value(0);
    end
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(msg.size() - 1);
      while (msg.size() > cut + 1) void'(msg.pop_back());
    end
    send_msg();
  endtask

  // sender stops offering until every predicted record has come out
  task wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task run_phase(int s_idle, int r_idle, int items);
    int stop_at;
    send_idle = s_idle;
    recv_idle = r_idle;
    stop_at = items_sent + items;
    while (items_sent < stop_at) random_msg();
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sb.mismatches = 0;
    cycles = 0;
    hold_left = 0;
    items_sent = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    data_byte <= 8'd0;
    last <= 1'b0;
    out_stall <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bytes token ending the message
    msg = '{8'h00};
    send_msg();
    // one-char string, then empty string and a reference to the first string
    msg = '{8'h21, 8'h41, 8'h00, 8'h20, 8'h00, 8'h82};
    send_msg();
    // object with max key, child of type code 5 with largest short length
    msg = '{8'h61, 8'hFF, 8'hFF, 8'hBB};
    send_msg();
    // four length bytes, all ones
    msg = '{8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_msg();
    // allocation hint inside an array
    msg = '{8'h42, 8'hC5, 8'hC0};
    send_msg();
    // reference to an array, bad
    msg = '{8'h40, 8'h82};
    send_msg();
    // unterminated string
    msg = '{8'h21, 8'h41, 8'h07};
    send_msg();
    // open container at the end
    msg = '{8'h42};
    send_msg();
    wait_drained();

    run_phase(9, 50, 285);
    run_phase(50, 9, 285);
    send_idle = 0;
    recv_idle = 0;

    // long receiver hold-off while the sender keeps offering
    hold_left = 300;
    repeat (40) msg.push_back({btsd_pkg::TY_BYTES, 5'd0});
    send_msg();
    // sender waits for everything to come back
    wait_drained();

    // table overflow: one more token than the table holds
    repeat (btsd_pkg::MAX_TOKENS + 1) msg.push_back({btsd_pkg::TY_NULL, 5'd0});
    send_msg();

    run_phase(0, 0, 285);

    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[binary_token_stream_decoder_unit] OK");
    end else begin
      $display("[binary_token_stream_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/btsd_pkg.sv
hdl/binary_token_stream_decoder_unit.sv
test/binary_token_stream_decoder_unit_test.sv
